>>> rtl/pmst_pkg.sv
// Package with sizes, payload structs and sequencer states for the spanning-tree block.
package pmst_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 512;
    localparam int WEIGHT_BITS  = 16;
    localparam int VIDX_W       = 6;
    localparam int EIDX_W       = 9;
    localparam int ECNT_W       = 10;
    localparam int VCNT_W       = 7;
    localparam int TOTAL_W      = 22;
    localparam int EDGE_W       = 2 * VIDX_W + WEIGHT_BITS;

    typedef struct packed {
        logic [5:0]  from_vertex;
        logic [5:0]  to_vertex;
        logic [15:0] weight;
        logic        entry_valid;
        logic        last_entry;
    } t_in;

    typedef struct packed {
        logic [21:0] total_weight;
        logic [6:0]  reached_count;
        logic        overflow;
    } t_out;

    typedef struct packed {
        logic [VIDX_W-1:0]      from_vertex;
        logic [VIDX_W-1:0]      to_vertex;
        logic [WEIGHT_BITS-1:0] weight;
    } t_edge;

    typedef enum logic [3:0] {
        S_LOAD,
        S_INIT,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_PICK,
        S_E_RD,
        S_E_CHK,
        S_K_CHK,
        S_FIN
    } t_state;

endpackage

>>> rtl/pmst_edge_store.sv
// Edge store: one write port, one registered read port.
module pmst_edge_store
    import pmst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [EIDX_W-1:0] i_waddr,
    input  t_edge             i_wdata,
    input  logic [EIDX_W-1:0] i_raddr,
    output t_edge             o_rdata
);

    t_edge r_mem [MAX_EDGES];
    t_edge r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/prim_mst_total_weight.sv
// Top level of the Prim minimum spanning tree total weight block.
// Edge entries are taken one per cycle while loading, up to 512 stored; later ones are
// dropped and flagged. The entry marked last starts a run from vertex 0. Every round scans
// all n configured vertices and picks the best one, or ends the run when none is left. It
// then walks every stored edge and does a key check on each entry that leaves the chosen
// vertex for an unvisited vertex below n. The key memory and the edge memory each have one
// read port and one write port. The final state moves the result to the output register,
// and the block waits in it while an earlier result is still stalled. No entry is taken
// until the result has moved.
module prim_mst_total_weight
    import pmst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [VCNT_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in               i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out              o_out
);

    t_state r_state, n_state;

    logic [VCNT_W-1:0]      r_vcount;
    logic [VCNT_W-1:0]      r_n;
    logic [ECNT_W-1:0]      r_ecount;
    logic                   r_dropped;
    logic [ECNT_W-1:0]      r_e;
    logic [VCNT_W-1:0]      r_i;
    logic                   r_found;
    logic [VIDX_W-1:0]      r_best;
    logic [WEIGHT_BITS-1:0] r_best_key;
    logic [MAX_VERTICES-1:0] r_visited;
    logic [MAX_VERTICES-1:0] r_keyset;
    logic [TOTAL_W-1:0]     r_total;
    logic [VCNT_W-1:0]      r_reached;
    logic [VIDX_W-1:0]      r_to;
    logic [WEIGHT_BITS-1:0] r_w;
    logic                   r_out_valid;
    t_out                   r_out;

    logic [WEIGHT_BITS-1:0] r_key_mem [MAX_VERTICES];
    logic [WEIGHT_BITS-1:0] r_key_rd;
    logic [VIDX_W-1:0]      key_raddr;
    logic                   key_we;
    logic [VIDX_W-1:0]      key_waddr;
    logic [WEIGHT_BITS-1:0] key_wdata;

    logic  in_acc;
    logic  edge_we;
    t_edge edge_wdata;
    t_edge edge_rd;
    logic  edge_hit;
    logic  key_better;
    logic  scan_better;

    assign o_in_stall  = (r_state != S_LOAD);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Edge store writes while loading.
    assign edge_we    = in_acc && i_in.entry_valid && (r_ecount < ECNT_W'(MAX_EDGES));
    assign edge_wdata = '{from_vertex: i_in.from_vertex, to_vertex: i_in.to_vertex,
                          weight: i_in.weight};

    pmst_edge_store u_edges (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (r_ecount[EIDX_W-1:0]),
        .i_wdata (edge_wdata),
        .i_raddr (r_e[EIDX_W-1:0]),
        .o_rdata (edge_rd)
    );

    // Key memory with a registered read.
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key_mem[key_waddr] <= key_wdata;
        end
        r_key_rd <= r_key_mem[key_raddr];
    end

    // Compare results used by the sequencer.
    assign scan_better = !r_visited[r_i[VIDX_W-1:0]] && r_keyset[r_i[VIDX_W-1:0]] &&
                         (!r_found || (r_key_rd < r_best_key));
    assign edge_hit    = (edge_rd.from_vertex == r_best) &&
                         ({1'b0, edge_rd.to_vertex} < r_n) &&
                         !r_visited[edge_rd.to_vertex];
    assign key_better  = !r_keyset[r_to] || (r_w < r_key_rd);

    // Key memory port selection.
    always_comb begin
        key_raddr = (r_state == S_E_CHK) ? edge_rd.to_vertex : r_i[VIDX_W-1:0];
        key_we    = 1'b0;
        key_waddr = r_to;
        key_wdata = r_w;
        if (r_state == S_INIT) begin
            key_we    = 1'b1;
            key_waddr = '0;
            key_wdata = '0;
        end else if (r_state == S_K_CHK && key_better) begin
            key_we = 1'b1;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD:     if (in_acc && i_in.last_entry) n_state = S_INIT;
            S_INIT:     n_state = S_SCAN_RD;
            S_SCAN_RD:  n_state = (r_i == r_n) ? S_PICK : S_SCAN_CMP;
            S_SCAN_CMP: n_state = S_SCAN_RD;
            S_PICK:     n_state = r_found ? S_E_RD : S_FIN;
            S_E_RD:     n_state = (r_e == r_ecount) ? S_SCAN_RD : S_E_CHK;
            S_E_CHK:    n_state = edge_hit ? S_K_CHK : S_E_RD;
            S_K_CHK:    n_state = S_E_RD;
            S_FIN:      if (!r_out_valid) n_state = S_LOAD;
            default:    n_state = S_LOAD;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount    <= VCNT_W'(MAX_VERTICES);
            r_ecount    <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_visited   <= '0;
            r_keyset    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_vcount <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (edge_we) begin
                        r_ecount <= r_ecount + 1'b1;
                    end else if (in_acc && i_in.entry_valid) begin
                        r_dropped <= 1'b1;
                    end
                end
                S_INIT: begin
                    r_visited <= '0;
                    r_keyset  <= MAX_VERTICES'(1);
                    r_found   <= 1'b0;
                end
                S_SCAN_CMP: begin
                    if (scan_better) r_found <= 1'b1;
                end
                S_PICK: begin
                    if (r_found) r_visited[r_best] <= 1'b1;
                end
                S_E_RD: begin
                    if (r_e == r_ecount) r_found <= 1'b0;
                end
                S_K_CHK: begin
                    if (key_better) r_keyset[r_to] <= 1'b1;
                end
                S_FIN: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_ecount    <= '0;
                        r_dropped   <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_LOAD: begin
                if (r_vcount == '0) begin
                    r_n <= VCNT_W'(1);
                end else if (r_vcount > VCNT_W'(MAX_VERTICES)) begin
                    r_n <= VCNT_W'(MAX_VERTICES);
                end else begin
                    r_n <= r_vcount;
                end
            end
            S_INIT: begin
                r_total   <= '0;
                r_reached <= '0;
                r_i       <= '0;
            end
            S_SCAN_CMP: begin
                if (scan_better) begin
                    r_best     <= r_i[VIDX_W-1:0];
                    r_best_key <= r_key_rd;
                end
                r_i <= r_i + 1'b1;
            end
            S_PICK: begin
                if (r_found) begin
                    r_total   <= r_total + TOTAL_W'(r_best_key);
                    r_reached <= r_reached + 1'b1;
                end
                r_e <= '0;
            end
            S_E_RD: begin
                if (r_e == r_ecount) r_i <= '0;
            end
            S_E_CHK: begin
                r_to <= edge_rd.to_vertex;
                r_w  <= edge_rd.weight;
                if (!edge_hit) r_e <= r_e + 1'b1;
            end
            S_K_CHK: begin
                r_e <= r_e + 1'b1;
            end
            S_FIN: begin
                if (!r_out_valid) begin
                    r_out.total_weight  <= r_total;
                    r_out.reached_count <= r_reached;
                    r_out.overflow      <= r_dropped;
                end
            end
            default: ;
        endcase
    end

endmodule
